[rtl/core/msd_pkg.sv]
// ---------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the multichannel slip deframer.
// ---------------------------------------------------------------------------
package msd_pkg;

  localparam int NUM_CHAN_DEF = 4;
  localparam int MAX_LEN_DEF  = 255;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [2:0] KIND_HDR_OK  = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_END     = 3'd2;
  localparam logic [2:0] KIND_ABORT   = 3'd3;
  localparam logic [2:0] KIND_HDR_BAD = 3'd4;

  localparam int OUT_TDATA_W = 32;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [1:0] chan;
    logic [7:0] payload;
    logic [7:0] position;
    logic [3:0] busy_flags;
  } msd_res_t;

endpackage

[rtl/core/msd_decode.sv]
// ---------------------------------------------------------------------------
// msd_decode
// Header/data pairing and per-channel slip receivers; one byte per step.
// ---------------------------------------------------------------------------
module msd_decode #(
  parameter int NUM_CHAN = msd_pkg::NUM_CHAN_DEF,
  parameter int MAX_LEN  = msd_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output msd_pkg::msd_res_t res
);

  localparam int CH_W = (NUM_CHAN > 1) ? $clog2(NUM_CHAN) : 1;

  typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_ESC, RX_ERR} rx_state_t;

  logic            exp_r, exp_nxt;
  logic [CH_W-1:0] cur_r, cur_nxt;
  logic [3:0]      busy_r, busy_nxt;
  rx_state_t       st_r  [NUM_CHAN];
  logic [7:0]      cnt_r [NUM_CHAN];

  rx_state_t       ch_st_nxt;
  logic [7:0]      ch_cnt_nxt;
  rx_state_t       ch_st;
  logic [7:0]      ch_cnt;
  logic [3:0]      sel;

  assign ch_st  = st_r[cur_r];
  assign ch_cnt = cnt_r[cur_r];
  assign sel    = rx_byte[3:0];

  always_comb begin
    exp_nxt        = exp_r;
    cur_nxt        = cur_r;
    busy_nxt       = busy_r;
    ch_st_nxt      = ch_st;
    ch_cnt_nxt     = ch_cnt;
    res.valid      = 1'b0;
    res.kind       = msd_pkg::KIND_HDR_OK;
    res.chan       = 2'(cur_r);
    res.payload    = 8'd0;
    res.position   = 8'd0;
    res.busy_flags = busy_r;
    if (!exp_r) begin
      busy_nxt       = rx_byte[7:4];
      res.busy_flags = rx_byte[7:4];
      res.valid      = 1'b1;
      if (sel < 4'(NUM_CHAN)) begin
        cur_nxt  = CH_W'(sel);
        exp_nxt  = 1'b1;
        res.kind = msd_pkg::KIND_HDR_OK;
        res.chan = 2'(sel);
      end else begin
        res.kind = msd_pkg::KIND_HDR_BAD;
      end
    end else begin
      exp_nxt = 1'b0;
      case (ch_st)
        RX_IDLE: begin
          if (rx_byte == msd_pkg::SLIP_END) begin
            ch_cnt_nxt = 8'd0;
            ch_st_nxt  = RX_DATA;
          end
        end
        RX_DATA, RX_ESC: begin
          if (ch_st == RX_DATA && rx_byte == msd_pkg::SLIP_END) begin
            ch_st_nxt    = RX_IDLE;
            res.valid    = 1'b1;
            res.kind     = msd_pkg::KIND_END;
            res.position = ch_cnt;
          end else if (ch_st == RX_DATA && rx_byte == msd_pkg::SLIP_ESC) begin
            ch_st_nxt = RX_ESC;
          end else if (ch_st == RX_ESC && rx_byte != msd_pkg::SLIP_ESC_END
                       && rx_byte != msd_pkg::SLIP_ESC_ESC) begin
            ch_st_nxt = RX_ERR;
            res.valid = 1'b1;
            res.kind  = msd_pkg::KIND_ABORT;
          end else if (ch_cnt >= 8'(MAX_LEN)) begin
            // frame would grow past the limit
            ch_st_nxt = RX_ERR;
            res.valid = 1'b1;
            res.kind  = msd_pkg::KIND_ABORT;
          end else begin
            ch_st_nxt    = RX_DATA;
            ch_cnt_nxt   = 8'(ch_cnt + 8'd1);
            res.valid    = 1'b1;
            res.kind     = msd_pkg::KIND_DATA;
            res.position = ch_cnt;
            if (ch_st == RX_DATA) begin
              res.payload = rx_byte;
            end else if (rx_byte == msd_pkg::SLIP_ESC_END) begin
              res.payload = msd_pkg::SLIP_END;
            end else begin
              res.payload = msd_pkg::SLIP_ESC;
            end
          end
        end
        default: begin
          if (rx_byte == msd_pkg::SLIP_END) begin
            ch_st_nxt = RX_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= 1'b0;
      cur_r  <= '0;
      busy_r <= 4'd0;
      for (int i = 0; i < NUM_CHAN; i++) begin
        st_r[i]  <= RX_IDLE;
        cnt_r[i] <= 8'd0;
      end
    end else if (step) begin
      exp_r  <= exp_nxt;
      cur_r  <= cur_nxt;
      busy_r <= busy_nxt;
      if (exp_r) begin
        st_r[cur_r]  <= ch_st_nxt;
        cnt_r[cur_r] <= ch_cnt_nxt;
      end
    end
  end

`ifndef SYNTH
  a_hdr_ok_arms_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && !exp_r && sel < 4'(NUM_CHAN) |=> exp_r)
    else $error("accepted header did not arm data byte");

  a_data_returns_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    step && exp_r |=> !exp_r)
    else $error("data byte not followed by header");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[cur_r] <= 8'(MAX_LEN))
    else $error("byte count above frame limit");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid && res.kind == msd_pkg::KIND_DATA
    |=> cnt_r[$past(cur_r)] == 8'($past(res.position) + 8'd1))
    else $error("data position and byte count disagree");
`endif

endmodule

[rtl/core/msd_out_reg.sv]
// ---------------------------------------------------------------------------
// msd_out_reg
// Result register: packs one result into the output stream word.
// ---------------------------------------------------------------------------
module msd_out_reg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  msd_pkg::msd_res_t                  res,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [msd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic                            vld_r, vld_nxt;
  logic [msd_pkg::OUT_TDATA_W-1:0] dat_r, dat_nxt;

  always_comb begin
    vld_nxt = vld_r;
    dat_nxt = dat_r;
    if (load) begin
      vld_nxt = 1'b1;
      dat_nxt = {7'd0, res.busy_flags, res.position, res.payload, res.chan, res.kind};
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    dat_r <= dat_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = dat_r;

endmodule

[rtl/core/multichannel_slip_deframer_unit.sv]
// data path: a byte is registered at the input, decoded from that register and
//   its result loaded into the output register when the byte steps on
// throughput: one byte per cycle unless a result waits on a stalled output;
//   each receiver update is one pass of logic between input and result registers
// reset: synchronous active-low rst_n clears pairing, channel, busy flags and
//   all receiver states and counts at once; no clearing pass
// ---------------------------------------------------------------------------
// multichannel_slip_deframer_unit
// Top level: input register, decoder and result register on stream ports.
// ---------------------------------------------------------------------------
module multichannel_slip_deframer_unit #(
  parameter int NUM_CHAN = msd_pkg::NUM_CHAN_DEF,
  parameter int MAX_LEN  = msd_pkg::MAX_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] in_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] kind, [4:3] chan, [12:5] payload, [20:13] position,
  // [24:21] busy_flags, [31:25] zero
  output logic [msd_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic              s1_vld_r, s1_vld_nxt;
  logic [7:0]        s1_byte_r, s1_byte_nxt;
  logic              step;
  msd_pkg::msd_res_t res;

  // a byte moves on unless its result would overwrite a waiting one
  assign step      = s1_vld_r && (!res.valid || !out_tvalid || out_tready);
  assign in_tready = !s1_vld_r || step;

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    s1_byte_nxt = s1_byte_r;
    if (in_tvalid && in_tready) begin
      s1_vld_nxt  = 1'b1;
      s1_byte_nxt = in_tdata;
    end else if (step) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    s1_byte_r <= s1_byte_nxt;
  end

  msd_decode #(
    .NUM_CHAN (NUM_CHAN),
    .MAX_LEN  (MAX_LEN)
  ) u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  msd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && res.valid),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && s1_vld_r && res.valid |-> !step)
    else $error("waiting result overwritten");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !step |=> s1_vld_r && $stable(s1_byte_r))
    else $error("stalled input byte lost");

  a_no_load_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !step |-> !in_tready)
    else $error("input transfer taken while stalled");
`endif

endmodule

[tb/tb_multichannel_slip_deframer_unit.sv]
// ---------------------------------------------------------------------------
// tb_multichannel_slip_deframer_unit
// Streams header/data byte pairs into the deframer. A behavioral model
// of the pairing logic and of the four slip receivers predicts every
// result, and each result transfer is compared field by field against it.
// Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_multichannel_slip_deframer_unit;

  localparam int NUM_CHAN     = msd_pkg::NUM_CHAN_DEF;
  localparam int MAX_LEN      = msd_pkg::MAX_LEN_DEF;
  localparam int RANDOM_ITEMS = 420;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_ESC, RX_ERR} rx_mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] chan;
    logic [7:0] payload;
    logic [7:0] position;
    logic [3:0] busy_flags;
  } slip_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready;
  // [2:0] kind, [4:3] chan, [12:5] payload, [20:13] position,
  // [24:21] busy_flags, [31:25] zero
  logic [31:0] out_tdata;

  // deframer model state
  logic        want_data;
  logic [1:0]  cur_chan;
  logic [3:0]  busy_now;
  rx_mode_t    rx_mode [NUM_CHAN];
  logic [7:0]  frame_len [NUM_CHAN];

  slip_event_t due_events [$];
  logic [7:0]  chan_stream [NUM_CHAN][$];
  int          mismatches;
  logic        no_idle;

  multichannel_slip_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit store_byte(input logic [1:0] ch, input logic [7:0] v,
                                    inout slip_event_t ev);
    if (frame_len[ch] >= MAX_LEN) begin
      rx_mode[ch] = RX_ERR;
      ev.kind = msd_pkg::KIND_ABORT;
    end else begin
      ev.kind       = msd_pkg::KIND_DATA;
      ev.payload    = v;
      ev.position   = frame_len[ch];
      frame_len[ch] = frame_len[ch] + 8'd1;
      rx_mode[ch]   = RX_DATA;
    end
    return 1'b1;
  endfunction

  // returns 1 when the byte produces a result transfer
  function automatic bit deframe_byte(input logic [7:0] b, output slip_event_t ev);
    logic [1:0] ch;
    ev = '0;
    if (!want_data) begin
      busy_now      = b[7:4];
      ev.busy_flags = busy_now;
      if (b[3:0] < NUM_CHAN) begin
        cur_chan  = b[1:0];
        want_data = 1'b1;
        ev.kind   = msd_pkg::KIND_HDR_OK;
        ev.chan   = b[1:0];
      end else begin
        ev.kind = msd_pkg::KIND_HDR_BAD;
        ev.chan = cur_chan;
      end
      return 1'b1;
    end
    want_data     = 1'b0;
    ch            = cur_chan;
    ev.chan       = ch;
    ev.busy_flags = busy_now;
    case (rx_mode[ch])
      RX_IDLE: begin
        if (b == msd_pkg::SLIP_END) begin
          frame_len[ch] = 8'd0;
          rx_mode[ch]   = RX_DATA;
        end
        return 1'b0;
      end
      RX_DATA: begin
        if (b == msd_pkg::SLIP_END) begin
          rx_mode[ch] = RX_IDLE;
          ev.kind     = msd_pkg::KIND_END;
          ev.position = frame_len[ch];
          return 1'b1;
        end
        if (b == msd_pkg::SLIP_ESC) begin
          rx_mode[ch] = RX_ESC;
          return 1'b0;
        end
        return store_byte(ch, b, ev);
      end
      RX_ESC: begin
        if (b == msd_pkg::SLIP_ESC_END) return store_byte(ch, msd_pkg::SLIP_END, ev);
        if (b == msd_pkg::SLIP_ESC_ESC) return store_byte(ch, msd_pkg::SLIP_ESC, ev);
        rx_mode[ch] = RX_ERR;
        ev.kind     = msd_pkg::KIND_ABORT;
        return 1'b1;
      end
      default: begin
        if (b == msd_pkg::SLIP_END) rx_mode[ch] = RX_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // append one slip-encoded frame for a channel, now and then with a bad escape
  function automatic void queue_frame(input logic [1:0] ch);
    int unsigned len;
    int unsigned bad_at;
    int unsigned k;
    logic [7:0]  v;
    len    = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    bad_at = len;
    if (len != 0 && $urandom_range(0, 9) == 0) bad_at = $urandom_range(0, len - 1);
    chan_stream[ch].push_back(msd_pkg::SLIP_END);
    for (k = 0; k < len; k++) begin
      if (k == bad_at) begin
        chan_stream[ch].push_back(msd_pkg::SLIP_ESC);
        do v = 8'($urandom);
        while (v == msd_pkg::SLIP_ESC_END || v == msd_pkg::SLIP_ESC_ESC);
        chan_stream[ch].push_back(v);
      end
      case ($urandom_range(0, 9))
        0:       v = msd_pkg::SLIP_END;
        1:       v = msd_pkg::SLIP_ESC;
        default: v = 8'($urandom);
      endcase
      if (v == msd_pkg::SLIP_END) begin
        chan_stream[ch].push_back(msd_pkg::SLIP_ESC);
        chan_stream[ch].push_back(msd_pkg::SLIP_ESC_END);
      end else if (v == msd_pkg::SLIP_ESC) begin
        chan_stream[ch].push_back(msd_pkg::SLIP_ESC);
        chan_stream[ch].push_back(msd_pkg::SLIP_ESC_ESC);
      end else begin
        chan_stream[ch].push_back(v);
      end
    end
    chan_stream[ch].push_back(msd_pkg::SLIP_END);
  endfunction

  // one input transfer; valid is only lowered when a gap follows
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    slip_event_t ev;
    bit          has_result;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has_result = deframe_byte(b, ev);
    if (has_result) due_events.push_back(ev);
  endtask

  task automatic send_pair(input logic [3:0] busy, input logic [1:0] ch,
                           input logic [7:0] data);
    send_byte({busy, 2'b00, ch});
    send_byte(data);
  endtask

  task automatic test_headers_and_frames;
    send_byte(8'h0F);                               // rejected before any channel chosen
    send_pair(4'hF, 2'd0, msd_pkg::SLIP_END);       // frame start on channel 0
    send_pair(4'h3, 2'd0, msd_pkg::SLIP_END);       // empty frame
    send_pair(4'h5, 2'd1, msd_pkg::SLIP_END);
    send_pair(4'h5, 2'd1, 8'hFF);
    send_byte(8'hA7);                               // rejected, channel 1 stays current
    send_pair(4'h5, 2'd1, msd_pkg::SLIP_ESC);
    send_pair(4'h5, 2'd1, msd_pkg::SLIP_ESC_END);
    send_pair(4'h9, 2'd1, msd_pkg::SLIP_ESC);
    send_pair(4'h9, 2'd1, msd_pkg::SLIP_ESC_ESC);
    send_pair(4'h6, 2'd1, msd_pkg::SLIP_END);       // frame end, length 3
  endtask

  task automatic test_bad_escape;
    send_pair(4'hC, 2'd3, msd_pkg::SLIP_END);
    send_pair(4'hC, 2'd3, msd_pkg::SLIP_ESC);
    send_pair(4'h0, 2'd3, 8'h00);                   // abort, receiver enters error
    send_pair(4'h0, 2'd3, 8'h41);                   // ignored while in error
    send_pair(4'hF, 2'd3, msd_pkg::SLIP_END);       // back to idle
  endtask

  task automatic test_overflow;
    int unsigned k;
    logic [7:0]  v;
    send_pair(4'($urandom_range(0, 15)), 2'd2, msd_pkg::SLIP_END);
    for (k = 0; k <= MAX_LEN; k++) begin
      do v = 8'($urandom); while (v == msd_pkg::SLIP_END || v == msd_pkg::SLIP_ESC);
      send_pair(4'($urandom_range(0, 15)), 2'd2, v);
    end
    send_pair(4'($urandom_range(0, 15)), 2'd2, msd_pkg::SLIP_END);
  endtask

  task automatic test_random_traffic;
    int unsigned n;
    int unsigned roll;
    logic [7:0]  b;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (!want_data) begin
        if (roll < 8) b = {4'($urandom_range(0, 15)), 4'($urandom_range(NUM_CHAN, 15))};
        else          b = {4'($urandom_range(0, 15)), 4'($urandom_range(0, NUM_CHAN - 1))};
      end else if (roll < 5) begin
        b = 8'($urandom);
      end else begin
        if (chan_stream[cur_chan].size() == 0) queue_frame(cur_chan);
        b = chan_stream[cur_chan].pop_front();
      end
      send_byte(b);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    out_tready = 1'b0;
    no_idle    = 1'b0;
    mismatches = 0;
    want_data  = 1'b0;
    cur_chan   = 2'd0;
    busy_now   = 4'h0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      rx_mode[i]   = RX_IDLE;
      frame_len[i] = 8'd0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_headers_and_frames();
    test_bad_escape();
    test_overflow();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_multichannel_slip_deframer_unit: clean");
    end else begin
      $display("tb_multichannel_slip_deframer_unit: errors");
    end
    $finish;
  end

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    slip_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_events.size() == 0) begin
        $error("unexpected result transfer, tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        if (out_tdata[2:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[4:3] !== want.chan) begin
          $error("chan: expected %0d, got %0d", want.chan, out_tdata[4:3]);
          mismatches++;
        end
        if (out_tdata[12:5] !== want.payload) begin
          $error("payload: expected %h, got %h", want.payload, out_tdata[12:5]);
          mismatches++;
        end
        if (out_tdata[20:13] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_tdata[20:13]);
          mismatches++;
        end
        if (out_tdata[24:21] !== want.busy_flags) begin
          $error("busy_flags: expected %h, got %h", want.busy_flags, out_tdata[24:21]);
          mismatches++;
        end
        if (out_tdata[31:25] !== 7'd0) begin
          $error("padding: expected 0, got %h", out_tdata[31:25]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_multichannel_slip_deframer_unit: errors");
    $finish;
  end

endmodule
